[hw/rtl/wrsd_pkg.sv]
// ============================================================================
// wrsd_pkg: shared types and constants of the weekly radio schedule decider
// Holds the channel payloads, the action codes and the command and status
// groups that pass between the controller and the datapath.
// ============================================================================
package wrsd_pkg;

    localparam logic [16:0] DAY_SECONDS  = 17'd86400;
    localparam logic [16:0] ERROR_SLEEP  = 17'd300;
    localparam logic [16:0] SLEEP_MARGIN = 17'd5;
    localparam logic [16:0] SLEEP_MAX    = 17'd131071;
    localparam logic [2:0]  SUNDAY       = 3'd0;
    localparam logic [2:0]  SATURDAY     = 3'd6;

    typedef enum logic [1:0] {
        ACT_CHECK = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_HOLD  = 2'd2
    } t_action;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  weekday;
        logic [16:0] second_of_day;
        logic        current_radio_on;
        logic [3:0]  entry_index;
        logic [16:0] entry_on_time;
        logic [6:0]  entry_on_days;
        logic [16:0] entry_off_time;
        logic [6:0]  entry_off_days;
    } t_in_item;

    typedef struct packed {
        logic        radio_on;
        logic [16:0] sleep_seconds;
        logic        time_error;
    } t_out_item;

    typedef struct packed {
        logic in_ready;
        logic write;
        logic hold_set;
        logic capture;
        logic pass_start;
        logic scan;
        logic use_yday;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic       in_fire;
        logic [1:0] action;
        logic       pass_done;
        logic       today_ok;
        logic       err;
        logic       out_free;
    } t_stat;

endpackage

[hw/rtl/wrsd_if.sv]
// ============================================================================
// wrsd_if: valid/ready channels of the schedule decider
// One interface for the request beats and one for the result beats.
// ============================================================================
interface wrsd_in_if
    import wrsd_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface wrsd_out_if
    import wrsd_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

[hw/rtl/wrsd_ctrl.sv]
// ============================================================================
// wrsd_ctrl: sequencer of the schedule decider
// Decodes accepted beats, runs the today and yesterday scan passes and
// hands the finished decision to the output register.
// ============================================================================
module wrsd_ctrl
    import wrsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_pass_y, n_pass_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pass_y <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pass_y <= n_pass_y;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_pass_y = r_pass_y;
        o_cmd    = '0;
        o_cmd.use_yday = r_pass_y;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_fire) begin
                    case (i_stat.action)
                        ACT_WRITE: o_cmd.write = 1'b1;
                        ACT_HOLD:  o_cmd.hold_set = 1'b1;
                        ACT_CHECK: begin
                            o_cmd.capture    = 1'b1;
                            o_cmd.pass_start = 1'b1;
                            n_pass_y         = 1'b0;
                            n_state          = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_stat.err) begin
                    n_state = S_FINISH;
                end else if (!i_stat.pass_done) begin
                    o_cmd.scan = 1'b1;
                end else if (!r_pass_y && !i_stat.today_ok) begin
                    // Nothing has happened yet today: look at yesterday.
                    o_cmd.pass_start = 1'b1;
                    n_pass_y         = 1'b1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[hw/rtl/wrsd_dp.sv]
// ============================================================================
// wrsd_dp: datapath of the schedule decider
// Schedule memory, scan counter, nearest-event accumulators, event and hold
// state, configuration register and the output register.
// ============================================================================
module wrsd_dp
    import wrsd_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    wrsd_in_if.sink     i_in,
    wrsd_out_if.source  o_out,
    input  t_cmd        i_cmd,
    output t_stat       o_stat
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NW    = $clog2(MAX_ENTRIES + 1);
    localparam int CNT_W = (NW > 5) ? NW : 5;
    localparam int WI_W  = (AW > 4) ? AW : 4;

    typedef struct packed {
        logic [16:0] on_time;
        logic [6:0]  on_days;
        logic [16:0] off_time;
        logic [6:0]  off_days;
    } t_entry;

    function automatic logic day_hit(input logic [6:0] mask, input logic [2:0] day);
        logic hit;
        hit = 1'b0;
        if (day < 3'd7) begin
            hit = mask[day];
        end
        return hit;
    endfunction

    t_entry      r_mem [MAX_ENTRIES];
    t_entry      r_rd_data;
    logic [4:0]  r_cfg_count;
    logic [CNT_W-1:0] r_rd_addr;
    logic        r_pend;

    logic [2:0]  r_wday, r_yday;
    logic [16:0] r_now;
    logic        r_cur, r_err;

    logic        r_on_ok, r_off_ok, r_onx_ok, r_offx_ok;
    logic [16:0] r_on_pre, r_off_pre, r_on_nx, r_off_nx;

    logic        r_lvalid, r_hold;
    logic [2:0]  r_lday;
    logic [16:0] r_lsec;

    logic        r_out_valid;
    t_out_item   r_out_item;

    logic [CNT_W-1:0] w_n;
    logic [WI_W-1:0]  w_wr_idx;
    logic        w_wr_ok, w_more, w_out_free, w_fire;
    logic [2:0]  w_day;
    logic        w_on_hit, w_off_hit, w_on_past, w_off_past;

    assign w_fire   = i_in.valid && i_cmd.in_ready;
    assign w_n      = (int'(r_cfg_count) >= MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                         : CNT_W'(r_cfg_count);
    assign w_wr_idx = WI_W'(i_in.item.entry_index);
    assign w_wr_ok  = int'(i_in.item.entry_index) < MAX_ENTRIES;
    assign w_more   = r_rd_addr < w_n;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_day    = i_cmd.use_yday ? r_yday : r_wday;

    assign i_in.ready  = i_cmd.in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

    always_comb begin
        o_stat.in_fire   = w_fire;
        o_stat.action    = i_in.item.action;
        o_stat.pass_done = !w_more && !r_pend;
        o_stat.today_ok  = r_on_ok || r_off_ok;
        o_stat.err       = r_err;
        o_stat.out_free  = w_out_free;
    end

    // Schedule memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && w_wr_ok) begin
            r_mem[w_wr_idx[AW-1:0]] <= '{on_time:  i_in.item.entry_on_time,
                                         on_days:  i_in.item.entry_on_days,
                                         off_time: i_in.item.entry_off_time,
                                         off_days: i_in.item.entry_off_days};
        end
        if (i_cmd.scan && w_more) begin
            r_rd_data <= r_mem[r_rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= '0;
        end else if (i_cfg_we) begin
            r_cfg_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
            r_pend    <= 1'b0;
        end else if (i_cmd.pass_start) begin
            r_rd_addr <= '0;
            r_pend    <= 1'b0;
        end else if (i_cmd.scan && w_more) begin
            r_rd_addr <= r_rd_addr + CNT_W'(1);
            r_pend    <= 1'b1;
        end else begin
            r_pend    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_wday <= i_in.item.weekday;
            r_yday <= (i_in.item.weekday == SUNDAY) ? SATURDAY
                                                    : i_in.item.weekday - 3'd1;
            r_now  <= i_in.item.second_of_day;
            r_cur  <= i_in.item.current_radio_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (i_cmd.capture) begin
            r_err <= i_in.item.second_of_day > DAY_SECONDS;
        end
    end

    // Yesterday's pass counts every matching event as already past.
    assign w_on_hit   = day_hit(r_rd_data.on_days, w_day);
    assign w_off_hit  = day_hit(r_rd_data.off_days, w_day);
    assign w_on_past  = i_cmd.use_yday || (r_now >= r_rd_data.on_time);
    assign w_off_past = i_cmd.use_yday || (r_now >= r_rd_data.off_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_ok   <= 1'b0;
            r_off_ok  <= 1'b0;
            r_onx_ok  <= 1'b0;
            r_offx_ok <= 1'b0;
        end else if (i_cmd.capture) begin
            r_on_ok   <= 1'b0;
            r_off_ok  <= 1'b0;
            r_onx_ok  <= 1'b0;
            r_offx_ok <= 1'b0;
        end else if (r_pend) begin
            if (w_on_hit && w_on_past) begin
                if (!r_on_ok || r_rd_data.on_time > r_on_pre) begin
                    r_on_ok  <= 1'b1;
                    r_on_pre <= r_rd_data.on_time;
                end
            end else if (w_on_hit) begin
                if (!r_onx_ok || r_rd_data.on_time < r_on_nx) begin
                    r_onx_ok <= 1'b1;
                    r_on_nx  <= r_rd_data.on_time;
                end
            end
            if (w_off_hit && w_off_past) begin
                if (!r_off_ok || r_rd_data.off_time > r_off_pre) begin
                    r_off_ok  <= 1'b1;
                    r_off_pre <= r_rd_data.off_time;
                end
            end else if (w_off_hit) begin
                if (!r_offx_ok || r_rd_data.off_time < r_off_nx) begin
                    r_offx_ok <= 1'b1;
                    r_off_nx  <= r_rd_data.off_time;
                end
            end
        end
    end

    // Final decision.
    logic [16:0] w_nx, w_ev, w_sleep;
    logic [17:0] w_sum;
    logic        w_use_on, w_any_ok, w_new, w_radio;

    always_comb begin
        if (r_onx_ok && r_offx_ok) begin
            w_nx = (r_on_nx >= r_off_nx) ? r_off_nx : r_on_nx;
        end else if (r_onx_ok) begin
            w_nx = r_on_nx;
        end else if (r_offx_ok) begin
            w_nx = r_off_nx;
        end else begin
            w_nx = DAY_SECONDS;
        end
        w_sum   = {1'b0, w_nx} - {1'b0, r_now} + {1'b0, SLEEP_MARGIN};
        w_sleep = w_sum[17] ? SLEEP_MAX : w_sum[16:0];

        w_any_ok = r_on_ok || r_off_ok;
        w_use_on = r_on_ok && (!r_off_ok || r_on_pre >= r_off_pre);
        w_ev     = w_use_on ? r_on_pre : r_off_pre;
        w_new    = r_lvalid && (r_lday != w_day || r_lsec != w_ev);
        if (w_any_ok) begin
            w_radio = (!w_new && r_hold) ? r_cur : w_use_on;
        end else begin
            w_radio = r_hold ? r_cur : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvalid <= 1'b0;
            r_lday   <= '0;
            r_lsec   <= '0;
            r_hold   <= 1'b0;
        end else if (i_cmd.hold_set) begin
            r_hold <= 1'b1;
        end else if (i_cmd.finish && !r_err) begin
            if (w_any_ok) begin
                r_lvalid <= 1'b1;
                r_lday   <= w_day;
                r_lsec   <= w_ev;
                if (w_new) begin
                    r_hold <= 1'b0;
                end
            end else if (!r_lvalid) begin
                r_lvalid <= 1'b1;
                r_lday   <= r_wday;
                r_lsec   <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_err) begin
                r_out_item <= '{radio_on: r_cur, sleep_seconds: ERROR_SLEEP,
                                time_error: 1'b1};
            end else begin
                r_out_item <= '{radio_on: w_radio, sleep_seconds: w_sleep,
                                time_error: 1'b0};
            end
        end
    end

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> w_out_free)
        else $error("result loaded over a beat that was not taken");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid && r_out_item.time_error == $past(r_err))
        else $error("finished check did not show the expected result");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> r_rd_addr <= w_n)
        else $error("scan address ran past the entry count");

endmodule

[hw/rtl/weekly_radio_schedule_decider.sv]
// ============================================================================
// weekly_radio_schedule_decider: weekly on/off schedule evaluation
// Stores up to MAX_ENTRIES switch-on/switch-off entries with weekday masks
// and decides the radio state and the time to the next check.
// ============================================================================
//
//  Channel   Direction  Handshake        Payload
//  i_in      in         valid/ready      action, weekday, time, entry fields
//  o_out     out        valid/ready      radio_on, sleep_seconds, time_error
//  i_cfg_*   in         write enable     entry_count (5 bits)
//
//  A write or hold beat is done as it is accepted. A check beat walks the n
//  entries in use over the single registered read port, folds in the last
//  entry and sees the pass end; when today has no past event, a second pass
//  over yesterday follows. The output register is loaded after the scan;
//  a time out of range skips the scan and loads the error result.
//  Reset is synchronous and active low; the schedule memory is not cleared.
//  A result waits in the output register while the next beat is accepted;
//  a later check holds in its final state until that register is free.
//
// The controller only sequences; all storage and arithmetic live in the
// datapath. Configuration is expected to change only while the block is idle.

module weekly_radio_schedule_decider
    import wrsd_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    wrsd_in_if.sink    i_in,
    wrsd_out_if.source o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer: decodes each accepted beat and steps through the passes.
    wrsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Datapath: memory, scan accumulators, event state and output register.
    wrsd_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

endmodule

[sim/weekly_radio_schedule_decider_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// weekly_radio_schedule_decider_tb: self-checking bench for the schedule decider
// Drives request beats with random idle bursts and stalls on the result side.
// A scoreboard keeps its own copy of the schedule and event state and checks
// every result beat in order.
// ============================================================================

class decision_scoreboard;

    localparam int SLOTS = 16;

    logic [16:0] on_time  [SLOTS];
    logic [6:0]  on_days  [SLOTS];
    logic [16:0] off_time [SLOTS];
    logic [6:0]  off_days [SLOTS];
    bit          event_valid;
    logic [2:0]  event_day;
    logic [16:0] event_second;
    bit          hold_flag;
    logic [4:0]  entry_count;
    wrsd_pkg::t_out_item pending_decisions[$];
    int          fault_count;

    function new();
        for (int i = 0; i < SLOTS; i++) begin
            on_time[i]  = '0;
            on_days[i]  = '0;
            off_time[i] = '0;
            off_days[i] = '0;
        end
        event_valid  = 1'b0;
        event_day    = '0;
        event_second = '0;
        hold_flag    = 1'b0;
        entry_count  = '0;
        fault_count  = 0;
    endfunction

    function void set_entry_count(logic [4:0] value);
        entry_count = value;
    endfunction

    function bit day_selected(logic [6:0] mask, logic [2:0] day);
        return (day < 3'd7) ? mask[day] : 1'b0;
    endfunction

    // Records the deciding event; returns 1 when the manual hold keeps the state.
    function bit hold_keeps(logic [2:0] day, logic [16:0] second);
        if (!event_valid) begin
            event_valid  = 1'b1;
            event_day    = day;
            event_second = second;
        end
        if (event_day != day || event_second != second) begin
            event_day    = day;
            event_second = second;
            hold_flag    = 1'b0;
            return 1'b0;
        end
        return hold_flag;
    endfunction

    // An on event wins a tie with an off event at the same second.
    function bit scheduled_state(bit on_ok, logic [16:0] on_last, bit off_ok,
                                 logic [16:0] off_last, logic [2:0] day, bit cur);
        bit          use_on;
        logic [16:0] deciding;
        use_on   = on_ok && (!off_ok || on_last >= off_last);
        deciding = use_on ? on_last : off_last;
        if (hold_keeps(day, deciding))
            return cur;
        return use_on;
    endfunction

    function void note_request(wrsd_pkg::t_in_item req);
        wrsd_pkg::t_out_item decision;
        int                  n;
        bit                  on_ok, off_ok, on_ahead, off_ahead, radio;
        logic [16:0]         on_last, off_last, on_next, off_next, t, now;
        logic [2:0]          yday;
        int unsigned         due, sleep;
        case (req.action)
            wrsd_pkg::ACT_WRITE: begin
                on_time[req.entry_index]  = req.entry_on_time;
                on_days[req.entry_index]  = req.entry_on_days;
                off_time[req.entry_index] = req.entry_off_time;
                off_days[req.entry_index] = req.entry_off_days;
                return;
            end
            wrsd_pkg::ACT_HOLD: begin
                hold_flag = 1'b1;
                return;
            end
            wrsd_pkg::ACT_CHECK: begin
            end
            default: begin
                return;
            end
        endcase

        now = req.second_of_day;
        if (now > wrsd_pkg::DAY_SECONDS) begin
            decision.radio_on      = req.current_radio_on;
            decision.sleep_seconds = wrsd_pkg::ERROR_SLEEP;
            decision.time_error    = 1'b1;
            pending_decisions.push_back(decision);
            return;
        end

        n         = (entry_count < SLOTS) ? int'(entry_count) : SLOTS;
        on_ok     = 1'b0;
        off_ok    = 1'b0;
        on_ahead  = 1'b0;
        off_ahead = 1'b0;
        on_last   = '0;
        off_last  = '0;
        on_next   = '0;
        off_next  = '0;
        for (int i = 0; i < n; i++) begin
            if (day_selected(on_days[i], req.weekday)) begin
                t = on_time[i];
                if (now >= t) begin
                    if (!on_ok || t > on_last) begin
                        on_last = t;
                        on_ok   = 1'b1;
                    end
                end else if (!on_ahead || t < on_next) begin
                    on_next  = t;
                    on_ahead = 1'b1;
                end
            end
            if (day_selected(off_days[i], req.weekday)) begin
                t = off_time[i];
                if (now >= t) begin
                    if (!off_ok || t > off_last) begin
                        off_last = t;
                        off_ok   = 1'b1;
                    end
                end else if (!off_ahead || t < off_next) begin
                    off_next  = t;
                    off_ahead = 1'b1;
                end
            end
        end

        due = wrsd_pkg::DAY_SECONDS;
        if (on_ahead)
            due = on_next;
        if (off_ahead && (!on_ahead || off_next < on_next))
            due = off_next;
        sleep = due - int'(now) + wrsd_pkg::SLEEP_MARGIN;
        if (sleep > wrsd_pkg::SLEEP_MAX)
            sleep = wrsd_pkg::SLEEP_MAX;

        if (on_ok || off_ok) begin
            radio = scheduled_state(on_ok, on_last, off_ok, off_last, req.weekday,
                                    req.current_radio_on);
        end else begin
            yday = (req.weekday == wrsd_pkg::SUNDAY) ? wrsd_pkg::SATURDAY
                                                     : req.weekday - 3'd1;
            for (int i = 0; i < n; i++) begin
                if (day_selected(on_days[i], yday)) begin
                    if (!on_ok || on_time[i] > on_last) begin
                        on_last = on_time[i];
                        on_ok   = 1'b1;
                    end
                end
                if (day_selected(off_days[i], yday)) begin
                    if (!off_ok || off_time[i] > off_last) begin
                        off_last = off_time[i];
                        off_ok   = 1'b1;
                    end
                end
            end
            if (on_ok || off_ok) begin
                radio = scheduled_state(on_ok, on_last, off_ok, off_last, yday,
                                        req.current_radio_on);
            end else begin
                radio = hold_flag ? req.current_radio_on : 1'b1;
                if (!event_valid) begin
                    event_valid  = 1'b1;
                    event_day    = req.weekday;
                    event_second = now;
                end
            end
        end

        decision.radio_on      = radio;
        decision.sleep_seconds = sleep[16:0];
        decision.time_error    = 1'b0;
        pending_decisions.push_back(decision);
    endfunction

    function void check_result(wrsd_pkg::t_out_item got);
        wrsd_pkg::t_out_item want;
        if (pending_decisions.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
                $display("%0t: unexpected result beat radio_on=%0d sleep=%0d time_error=%0d",
                         $time, got.radio_on, got.sleep_seconds, got.time_error);
            return;
        end
        want = pending_decisions.pop_front();
        if (got.radio_on !== want.radio_on || got.sleep_seconds !== want.sleep_seconds ||
            got.time_error !== want.time_error) begin
            fault_count++;
            if (fault_count <= 10)
                $display({"%0t: mismatch, expected radio_on=%0d sleep=%0d time_error=%0d,",
                          " got radio_on=%0d sleep=%0d time_error=%0d"},
                         $time, want.radio_on, want.sleep_seconds, want.time_error,
                         got.radio_on, got.sleep_seconds, got.time_error);
        end
    endfunction

endclass

module weekly_radio_schedule_decider_tb;
    import wrsd_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 11;
    localparam int SLOTS           = 16;
    // A check walks the table twice at most, so this covers any work still
    // in flight.
    localparam int DRAIN_CYCLES    = 2 * SLOTS + 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_data;

    wrsd_in_if  in_bus ();
    wrsd_out_if out_bus ();

    decision_scoreboard board;

    // Idle bursts on both sides are enabled per phase.
    bit          idle_on;
    int          stall_left = 0;
    int unsigned cycle_count = 0;

    // Stimulus-side view of the table contents, so that the generator never
    // depends on when the scoreboard sees a beat. It also tells which slots
    // were written, since a scan must never touch a slot that holds nothing.
    logic [16:0] slot_on_t  [SLOTS];
    logic [16:0] slot_off_t [SLOTS];
    bit          slot_set   [SLOTS];

    // The last check sent, repeated to hit the same deciding event again.
    logic [2:0]  last_wd;
    logic [16:0] last_sec;

    // Entry counts of the random phases: the full table, a single entry,
    // counts past the table depth, and an empty table among them.
    int phase_counts [NUM_PHASES] = '{16, 1, 31, 0, 9, 17, 16, 2, 12, 16};

    weekly_radio_schedule_decider #(
        .MAX_ENTRIES (SLOTS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Everything the block does is observed at the rising edge. Inputs only
    // change at the falling edge, so the values seen here are stable.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we)
                board.set_entry_count(cfg_data);
            if (in_bus.valid && in_bus.ready)
                board.note_request(in_bus.item);
            if (out_bus.valid && out_bus.ready)
                board.check_result(out_bus.item);
        end
    end

    // The result side stalls in random bursts while idling is on.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            out_bus.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 9);
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // A run that hangs ends here instead of running forever.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Every field gets random bits; callers overwrite the ones that matter.
    function automatic t_in_item random_fields();
        t_in_item beat;
        beat.action           = 2'($urandom_range(0, 3));
        beat.weekday          = 3'($urandom_range(0, 7));
        beat.second_of_day    = 17'($urandom_range(0, 131071));
        beat.current_radio_on = 1'($urandom_range(0, 1));
        beat.entry_index      = 4'($urandom_range(0, 15));
        beat.entry_on_time    = 17'($urandom_range(0, 131071));
        beat.entry_on_days    = 7'($urandom_range(0, 127));
        beat.entry_off_time   = 17'($urandom_range(0, 131071));
        beat.entry_off_days   = 7'($urandom_range(0, 127));
        return beat;
    endfunction

    // Presents one beat and returns at the edge where it is taken. Valid is
    // only lowered when an idle burst starts, never between two back-to-back
    // beats, so it is never lowered and raised in the same time step.
    task automatic send_beat(t_in_item beat);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            in_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_bus.valid <= 1'b1;
        in_bus.item  <= beat;
        do @(posedge clk); while (!in_bus.ready);
    endtask

    task automatic send_check(logic [2:0] wd, logic [16:0] sec, logic cur);
        t_in_item beat;
        beat                  = random_fields();
        beat.action           = ACT_CHECK;
        beat.weekday          = wd;
        beat.second_of_day    = sec;
        beat.current_radio_on = cur;
        last_wd  = wd;
        last_sec = sec;
        send_beat(beat);
    endtask

    task automatic send_entry(int idx, logic [16:0] on_t, logic [6:0] on_d,
                              logic [16:0] off_t, logic [6:0] off_d);
        t_in_item beat;
        beat                = random_fields();
        beat.action         = ACT_WRITE;
        beat.entry_index    = 4'(idx);
        beat.entry_on_time  = on_t;
        beat.entry_on_days  = on_d;
        beat.entry_off_time = off_t;
        beat.entry_off_days = off_d;
        slot_on_t[idx]  = on_t;
        slot_off_t[idx] = off_t;
        slot_set[idx]   = 1'b1;
        send_beat(beat);
    endtask

    task automatic send_hold();
        t_in_item beat;
        beat        = random_fields();
        beat.action = ACT_HOLD;
        send_beat(beat);
    endtask

    task automatic send_unused();
        t_in_item beat;
        beat        = random_fields();
        beat.action = ACT_UNUSED;
        send_beat(beat);
    endtask

    // Waits until every request has been taken and answered, then lets the
    // block finish any write or hold that produces no result.
    task automatic quiesce();
        @(negedge clk);
        in_bus.valid <= 1'b0;
        while (board.pending_decisions.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_entry_count(int value);
        quiesce();
        cfg_we   <= 1'b1;
        cfg_data <= 5'(value);
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Switch times mostly sit on a coarse grid so that entries collide and
    // ties between on and off events come up often. A few go past midnight,
    // which drives the sleep time into saturation.
    function automatic logic [16:0] pick_entry_time();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 17'($urandom_range(0, 143) * 600);
        if (pick < 85)
            return 17'($urandom_range(0, 86399));
        return 17'($urandom_range(0, 131071));
    endfunction

    function automatic logic [6:0] pick_mask();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 7'h7F;
        if (pick == 1)
            return 7'h00;
        return 7'($urandom_range(0, 127));
    endfunction

    // Check times land on or right next to stored switch times most often,
    // with the day boundary and out-of-range times mixed in.
    function automatic logic [16:0] pick_second();
        int          pick, slot;
        int unsigned near;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, SLOTS - 1);
        if (pick < 40 && slot_set[slot]) begin
            near = $urandom_range(0, 1) ? slot_on_t[slot] : slot_off_t[slot];
            near = near + $urandom_range(0, 4);
            near = (near >= 2) ? near - 2 : 0;
            if (near > SLEEP_MAX)
                near = SLEEP_MAX;
            return 17'(near);
        end
        if (pick < 65)
            return 17'($urandom_range(0, DAY_SECONDS));
        if (pick < 75)
            case ($urandom_range(0, 3))
                0:       return 17'd0;
                1:       return DAY_SECONDS - 17'd1;
                2:       return DAY_SECONDS;
                default: return DAY_SECONDS + 17'd1;
            endcase
        if (pick < 85)
            return 17'($urandom_range(DAY_SECONDS + 1, 131071));
        return 17'($urandom_range(0, 143) * 600);
    endfunction

    task automatic random_check();
        logic [2:0] wd;
        wd = ($urandom_range(0, 99) < 8) ? 3'd7 : 3'($urandom_range(0, 6));
        send_check(wd, pick_second(), 1'($urandom_range(0, 1)));
    endtask

    // One phase runs under one entry count. Slots about to be scanned are
    // filled first; after that most traffic is checks, with rewrites of the
    // table and hold sequences that revisit the same deciding event.
    task automatic random_phase(int count);
        int sent, pick, used;
        write_entry_count(count);
        sent = 0;
        used = (count < SLOTS) ? count : SLOTS;
        for (int i = 0; i < used; i++) begin
            if (!slot_set[i]) begin
                send_entry(i, pick_entry_time(), pick_mask(), pick_entry_time(), pick_mask());
                sent++;
            end
        end
        while (sent < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                random_check();
                sent++;
            end else if (pick < 68) begin
                send_entry($urandom_range(0, SLOTS - 1), pick_entry_time(), pick_mask(),
                           pick_entry_time(), pick_mask());
                sent++;
            end else if (pick < 80) begin
                // Hold, then ask again at the same moment: the hold should
                // keep whatever state the caller reports.
                random_check();
                send_hold();
                send_check(last_wd, last_sec, 1'($urandom_range(0, 1)));
                sent += 3;
                if ($urandom_range(0, 1)) begin
                    send_check(last_wd, last_sec, 1'($urandom_range(0, 1)));
                    sent++;
                end
            end else if (pick < 85) begin
                send_hold();
                sent++;
            end else if (pick < 88) begin
                // The block ignores this beat, so it does not count.
                send_unused();
            end else begin
                send_check(last_wd, last_sec, 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial begin
        board        = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        in_bus.valid = 1'b0;
        in_bus.item  = '0;
        out_bus.ready = 1'b0;
        idle_on      = 1'b1;
        last_wd      = '0;
        last_sec     = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_on_t[i]  = '0;
            slot_off_t[i] = '0;
            slot_set[i]   = 1'b0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty table: no events anywhere, so the radio defaults to on and
        // the first check records the current moment as the last event.
        send_check(3'd0, 17'd0, 1'b0);
        send_check(3'd7, DAY_SECONDS, 1'b1);
        // Times past the end of the day report an error and a fixed sleep.
        send_check(3'd3, DAY_SECONDS + 17'd1, 1'b0);
        send_check(3'd5, 17'd131071, 1'b1);
        // With the hold set and still nothing scheduled, the state is kept.
        send_hold();
        send_check(3'd3, 17'd1000, 1'b0);
        send_unused();

        // A small table: a weekday tie at 3600, Sunday on and Saturday off,
        // a switch time past midnight, and an entry with no on days.
        send_entry(0, 17'd3600, 7'h3E, 17'd3600, 7'h3E);
        send_entry(1, 17'd0, 7'h01, 17'd86399, 7'h40);
        send_entry(2, 17'd131071, 7'h7F, 17'd7200, 7'h02);
        send_entry(3, 17'd43200, 7'h00, 17'd120000, 7'h3E);
        write_entry_count(4);

        send_check(3'd1, 17'd3600, 1'b0);   // on and off at once: on wins
        send_check(3'd0, 17'd3, 1'b1);      // next event far away: sleep saturates
        send_check(3'd6, 17'd3, 1'b0);      // nothing past today: use Friday
        send_check(3'd7, 17'd5000, 1'b1);   // day seven falls back to Saturday
        send_hold();
        send_check(3'd7, 17'd5000, 1'b0);   // same deciding event: hold wins
        send_check(3'd2, DAY_SECONDS, 1'b1);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            idle_on <= (phase < NUM_PHASES - 1);
            random_phase(phase_counts[phase]);
        end

        quiesce();
        if (board.fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
